// ===== rtl/lmcfb_pkg.sv =====
// Package for the LED matrix chain frame builder.
// Holds the item and result types, mode and opcode constants and the controller/datapath links.
// Depends on nothing.
`timescale 1ns / 1ps

package lmcfb_pkg;

    localparam int ROW_W = 3;
    localparam int ROWS  = 8;
    localparam int CNT_W = 4;

    localparam logic [1:0] ADDR_UNIT_COUNT = 2'd0;

    localparam logic [2:0] MODE_ROW   = 3'd0;
    localparam logic [2:0] MODE_LED   = 3'd1;
    localparam logic [2:0] MODE_FLUSH = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_CTRL  = 3'd4;

    localparam logic [1:0] CTL_SHUTDOWN  = 2'd0;
    localparam logic [1:0] CTL_INTENSITY = 2'd1;
    localparam logic [1:0] CTL_SCANLIMIT = 2'd2;

    localparam logic [7:0] OPC_INTENSITY = 8'd10;
    localparam logic [7:0] OPC_SCANLIMIT = 8'd11;
    localparam logic [7:0] OPC_SHUTDOWN  = 8'd12;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] unit;
        logic       all_units;
        logic [2:0] row;
        logic [2:0] column;
        logic [7:0] value;
        logic       led_on;
        logic       defer;
        logic       changed_only;
        logic [1:0] control_op;
    } in_item_t;

    typedef struct packed {
        logic [15:0] chain_word;
        logic        frame_end;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ROW_DEFER,
        ACT_ROW_SEND,
        ACT_LED,
        ACT_FLUSH_ALL,
        ACT_FLUSH_CHG,
        ACT_CLEAR_ALL,
        ACT_CLEAR_ONE,
        ACT_CTRL_ALL,
        ACT_CTRL_ONE
    } action_t;

    typedef enum logic [1:0] {
        FK_ONE,
        FK_ALL,
        FK_FL_ALL,
        FK_FL_CHG
    } frame_kind_t;

    typedef struct packed {
        logic        load;
        logic        wr_row;
        logic        led_rd;
        logic        led_wr;
        logic        clr_all;
        logic        clr_one;
        logic        word_rd;
        logic        emit;
        logic        frame_end;
        logic        last;
        logic        op_from_frame;
        frame_kind_t kind;
        logic [2:0]  cur_unit;
        logic [2:0]  cur_frame;
    } dp_cmd_t;

    typedef struct packed {
        action_t          action;
        logic             flush_any;
        logic [CNT_W-1:0] unit_count;
    } dp_status_t;

endpackage

// ===== rtl/lmcfb_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module lmcfb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lmcfb_dp.sv =====
// Datapath of the LED matrix chain frame builder: item register, shadow rows, pending bits,
// the configuration register and the result register. Depends on lmcfb_pkg and lmcfb_ram.
`timescale 1ns / 1ps

module lmcfb_dp
    import lmcfb_pkg::*;
#(
    parameter int MAX_UNITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    item,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output out_item_t   result,
    output logic        result_valid
);

    localparam int UIDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int ADDR_W = UIDX_W + ROW_W;
    localparam int DEPTH  = MAX_UNITS * ROWS;
    localparam logic [CNT_W-1:0] UNITS_MAX = CNT_W'(MAX_UNITS);

    in_item_t            item_reg;
    logic [7:0]          op_reg;
    logic [7:0]          data_reg;
    logic [CNT_W-1:0]    unit_count_reg;
    logic [7:0]          pending_reg [MAX_UNITS];
    logic [DEPTH-1:0]    valid_reg;
    logic                rvalid_reg;
    logic [ROW_W-1:0]    d_reg;
    logic                has_reg;
    out_item_t           result_reg;
    logic                result_valid_reg;

    logic                unit_ok;
    logic                ctl_ok;
    logic [7:0]          ctl_op;
    logic [7:0]          ctl_data;
    logic [7:0]          cur_pend;
    logic [ROW_W-1:0]    low_d;
    logic [ROW_W-1:0]    pick_d;
    logic                pick_has;
    logic                is_flush;
    logic [ADDR_W-1:0]   raddr;
    logic [ADDR_W-1:0]   waddr;
    logic [7:0]          wdata;
    logic                we;
    logic                re;
    logic [7:0]          rdata;
    logic [7:0]          cur_row;
    logic [7:0]          led_mask;
    logic [7:0]          led_new;
    logic [7:0]          word_op;
    logic [15:0]         word;
    logic                any;
    logic [CNT_W-1:0]    cfg_value;
    logic                cfg_write;

    assign unit_ok = {1'b0, item_reg.unit} < unit_count_reg;

    always_comb
    begin
        ctl_ok = 1'b0;
        if (item_reg.control_op == CTL_SHUTDOWN)
        begin
            ctl_ok = 1'b1;
        end
        else if (item_reg.control_op == CTL_INTENSITY)
        begin
            ctl_ok = item_reg.value < 8'd16;
        end
        else if (item_reg.control_op == CTL_SCANLIMIT)
        begin
            ctl_ok = (item_reg.value >= 8'd1) && (item_reg.value <= 8'd8);
        end
    end

    always_comb
    begin
        status.action = ACT_NONE;
        unique case (item_reg.mode)
            MODE_ROW:
            begin
                if (unit_ok)
                begin
                    status.action = item_reg.defer ? ACT_ROW_DEFER : ACT_ROW_SEND;
                end
            end
            MODE_LED:
            begin
                if (unit_ok)
                begin
                    status.action = ACT_LED;
                end
            end
            MODE_FLUSH:
            begin
                status.action = item_reg.changed_only ? ACT_FLUSH_CHG : ACT_FLUSH_ALL;
            end
            MODE_CLEAR:
            begin
                if (item_reg.all_units)
                begin
                    status.action = ACT_CLEAR_ALL;
                end
                else if (unit_ok)
                begin
                    status.action = ACT_CLEAR_ONE;
                end
            end
            MODE_CTRL:
            begin
                if (ctl_ok && item_reg.all_units)
                begin
                    status.action = ACT_CTRL_ALL;
                end
                else if (ctl_ok && unit_ok)
                begin
                    status.action = ACT_CTRL_ONE;
                end
            end
            default:
            begin
                status.action = ACT_NONE;
            end
        endcase
    end

    always_comb
    begin
        any = 1'b0;
        for (int u = 0; u < MAX_UNITS; u++)
        begin
            if ((CNT_W'(u) < unit_count_reg) && (pending_reg[u] != 8'd0))
            begin
                any = 1'b1;
            end
        end
    end

    assign status.flush_any  = any;
    assign status.unit_count = unit_count_reg;

    always_comb
    begin
        ctl_op   = 8'd0;
        ctl_data = 8'd0;
        unique case (item.control_op)
            CTL_SHUTDOWN:
            begin
                ctl_op   = OPC_SHUTDOWN;
                ctl_data = {7'd0, ~item.value[0]};
            end
            CTL_INTENSITY:
            begin
                ctl_op   = OPC_INTENSITY;
                ctl_data = item.value;
            end
            CTL_SCANLIMIT:
            begin
                ctl_op   = OPC_SCANLIMIT;
                ctl_data = item.value - 8'd1;
            end
            default:
            begin
                ctl_op   = 8'd0;
                ctl_data = 8'd0;
            end
        endcase
    end

    assign cur_pend = pending_reg[cmd.cur_unit[UIDX_W-1:0]];

    always_comb
    begin
        low_d = '0;
        for (int b = ROWS - 1; b >= 0; b--)
        begin
            if (cur_pend[b])
            begin
                low_d = ROW_W'(b);
            end
        end
    end

    assign is_flush = (cmd.kind == FK_FL_ALL) || (cmd.kind == FK_FL_CHG);
    assign pick_d   = (cmd.kind == FK_FL_CHG) ? low_d : cmd.cur_frame;
    assign pick_has = (cmd.kind == FK_FL_CHG) ? (cur_pend != 8'd0) : 1'b1;

    assign raddr = cmd.led_rd ? {item_reg.unit[UIDX_W-1:0], item_reg.row}
                              : {cmd.cur_unit[UIDX_W-1:0], pick_d};
    assign re    = cmd.led_rd | cmd.word_rd;
    assign waddr = {item_reg.unit[UIDX_W-1:0], item_reg.row};
    assign we    = cmd.wr_row | cmd.led_wr;

    assign cur_row  = rvalid_reg ? rdata : 8'd0;
    assign led_mask = 8'h80 >> item_reg.column;
    assign led_new  = item_reg.led_on ? (cur_row | led_mask) : (cur_row & ~led_mask);
    assign wdata    = cmd.led_wr ? led_new : item_reg.value;

    lmcfb_ram #(
        .WIDTH  (8),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_shadow (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign word_op = cmd.op_from_frame ? ({5'd0, cmd.cur_frame} + 8'd1) : op_reg;

    always_comb
    begin
        word = 16'd0;
        unique case (cmd.kind)
            FK_ONE:
            begin
                if (cmd.cur_unit == item_reg.unit)
                begin
                    word = {word_op, data_reg};
                end
            end
            FK_ALL:
            begin
                word = {word_op, data_reg};
            end
            FK_FL_ALL, FK_FL_CHG:
            begin
                if (has_reg)
                begin
                    word = {({5'd0, d_reg} + 8'd1), cur_row};
                end
            end
            default:
            begin
                word = 16'd0;
            end
        endcase
    end

    assign cfg_value = pwdata[CNT_W-1:0];
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_UNIT_COUNT);
    assign prdata    = (paddr == ADDR_UNIT_COUNT) ? {28'd0, unit_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_count_reg   <= UNITS_MAX;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
            for (int u = 0; u < MAX_UNITS; u++)
            begin
                pending_reg[u] <= 8'd0;
            end
        end
        else
        begin
            if (cfg_write && (cfg_value >= 4'd1) && (cfg_value <= UNITS_MAX))
            begin
                unit_count_reg <= cfg_value;
            end
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.clr_all)
            begin
                valid_reg <= '0;
            end
            if (cmd.clr_one)
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    valid_reg[{item_reg.unit[UIDX_W-1:0], ROW_W'(r)}] <= 1'b0;
                end
            end
            if (cmd.wr_row && item_reg.defer)
            begin
                pending_reg[item_reg.unit[UIDX_W-1:0]][item_reg.row] <= 1'b1;
            end
            if (cmd.word_rd && is_flush && pick_has)
            begin
                pending_reg[cmd.cur_unit[UIDX_W-1:0]][pick_d] <= 1'b0;
            end
            result_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            if (item.mode == MODE_CTRL)
            begin
                op_reg   <= ctl_op;
                data_reg <= ctl_data;
            end
            else if (item.mode == MODE_CLEAR)
            begin
                op_reg   <= 8'd0;
                data_reg <= 8'd0;
            end
            else
            begin
                op_reg   <= {5'd0, item.row} + 8'd1;
                data_reg <= item.value;
            end
        end
        if (cmd.led_wr)
        begin
            data_reg <= led_new;
        end
        if (re)
        begin
            rvalid_reg <= valid_reg[raddr];
        end
        if (cmd.word_rd)
        begin
            d_reg   <= pick_d;
            has_reg <= pick_has;
        end
        if (cmd.emit)
        begin
            result_reg.chain_word <= word;
            result_reg.frame_end  <= cmd.frame_end;
            result_reg.last       <= cmd.last;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/lmcfb_ctrl.sv =====
// Controller of the LED matrix chain frame builder: sequences decode, shadow updates and
// the frame and word loops. Depends on lmcfb_pkg.
`timescale 1ns / 1ps

module lmcfb_ctrl
    import lmcfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LED_WR,
        S_WORD_RD,
        S_WORD_EMIT
    } state_t;

    state_t      state_reg;
    frame_kind_t kind_reg;
    logic        multi_reg;
    logic        opf_reg;
    logic [2:0]  unit_reg;
    logic [2:0]  frame_reg;

    logic [2:0]  top_unit;
    logic [CNT_W-1:0] top_count;
    logic        last_frame;

    assign top_count  = status.unit_count - 4'd1;
    assign top_unit   = top_count[2:0];
    assign last_frame = (kind_reg == FK_FL_CHG) ? !status.flush_any
                                                : (frame_reg == (multi_reg ? 3'd7 : 3'd0));
    assign busy       = (state_reg != S_IDLE);

    always_comb
    begin
        cmd               = '0;
        cmd.kind          = kind_reg;
        cmd.cur_unit      = unit_reg;
        cmd.cur_frame     = frame_reg;
        cmd.op_from_frame = opf_reg;
        cmd.frame_end     = (unit_reg == 3'd0);
        cmd.last          = (unit_reg == 3'd0) && last_frame;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_DECODE:
            begin
                cmd.wr_row  = (status.action == ACT_ROW_DEFER) ||
                              (status.action == ACT_ROW_SEND);
                cmd.led_rd  = (status.action == ACT_LED);
                cmd.clr_all = (status.action == ACT_CLEAR_ALL);
                cmd.clr_one = (status.action == ACT_CLEAR_ONE);
            end
            S_LED_WR:
            begin
                cmd.led_wr = 1'b1;
            end
            S_WORD_RD:
            begin
                cmd.word_rd = 1'b1;
            end
            S_WORD_EMIT:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= FK_ONE;
            multi_reg <= 1'b0;
            opf_reg   <= 1'b0;
            unit_reg  <= 3'd0;
            frame_reg <= 3'd0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    unit_reg  <= top_unit;
                    frame_reg <= 3'd0;
                    multi_reg <= 1'b0;
                    opf_reg   <= 1'b0;
                    kind_reg  <= FK_ONE;
                    state_reg <= S_WORD_RD;
                    unique case (status.action)
                        ACT_NONE, ACT_ROW_DEFER:
                        begin
                            state_reg <= S_IDLE;
                        end
                        ACT_ROW_SEND, ACT_CTRL_ONE:
                        begin
                            kind_reg <= FK_ONE;
                        end
                        ACT_LED:
                        begin
                            state_reg <= S_LED_WR;
                        end
                        ACT_CTRL_ALL:
                        begin
                            kind_reg <= FK_ALL;
                        end
                        ACT_CLEAR_ALL:
                        begin
                            kind_reg  <= FK_ALL;
                            multi_reg <= 1'b1;
                            opf_reg   <= 1'b1;
                        end
                        ACT_CLEAR_ONE:
                        begin
                            multi_reg <= 1'b1;
                            opf_reg   <= 1'b1;
                        end
                        ACT_FLUSH_ALL:
                        begin
                            kind_reg  <= FK_FL_ALL;
                            multi_reg <= 1'b1;
                        end
                        ACT_FLUSH_CHG:
                        begin
                            kind_reg <= FK_FL_CHG;
                            if (!status.flush_any)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_LED_WR:
                begin
                    state_reg <= S_WORD_RD;
                end
                S_WORD_RD:
                begin
                    state_reg <= S_WORD_EMIT;
                end
                S_WORD_EMIT:
                begin
                    if (unit_reg != 3'd0)
                    begin
                        unit_reg  <= unit_reg - 3'd1;
                        state_reg <= S_WORD_RD;
                    end
                    else if (last_frame)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        unit_reg  <= top_unit;
                        frame_reg <= frame_reg + 3'd1;
                        state_reg <= S_WORD_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/led_matrix_chain_frame_builder.sv =====
// Top level of the LED matrix chain frame builder.
// Joins lmcfb_ctrl and lmcfb_dp; depends on lmcfb_pkg.
//
// Commands enter on item with start; a transfer happens at a clock edge where start is
// high and busy is low. Results leave on result as 16-bit chain words, each
// marked by result_valid for exactly one cycle; the receiver cannot stall them. Words go
// out in chain shift order, the last unit first, with frame_end on the word of unit 0 and
// last on the final word that a command causes.
// Every word is made by a shadow row read and then an emit; a single-LED command first
// reads and rewrites its row.
// Deferred row writes and ignored commands keep busy high for one cycle and give no word.
// unit_count is written through the APB port at address 0; the user must write it only while the block is idle,
// as the block itself does not enforce this. Reset clears the pending bits, sets unit_count to the maximum and
// makes every shadow row read as zero through per-row valid bits; no clearing pass is needed.
`timescale 1ns / 1ps

module led_matrix_chain_frame_builder
    import lmcfb_pkg::*;
#(
    parameter int MAX_UNITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_item_t    item,
    output logic        busy,
    output logic        result_valid,
    output out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign pready = 1'b1;

    lmcfb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lmcfb_dp #(
        .MAX_UNITS (MAX_UNITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .result       (result),
        .result_valid (result_valid)
    );

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("Result word without an active command.");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> result.frame_end)
        else $error("Last word of a command does not end a frame.");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Command transfer did not make the block busy.");

endmodule
